FILE: rtl/fat_chain_engine_top_macros.svh
// Assertion macros for the file allocation table chain engine.
`ifndef FAT_CHAIN_ENGINE_TOP_MACROS_SVH
`define FAT_CHAIN_ENGINE_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Checked property, disabled while reset is asserted.
`define FCE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("fat chain engine assertion failed");

// Checked property, evaluated during reset too.
`define FCE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fat chain engine assertion failed");

`else

`define FCE_ASSERT(lbl, clk, rstn, prop)
`define FCE_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: rtl/fce_pkg.sv
// Shared types and constants of the file allocation table chain engine.
package fce_pkg;

  localparam int unsigned BLK_W   = 12;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned FREED_W = 13;

  localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

  // Table entry coding: free, end of chain, or next block plus LINK_BASE.
  localparam int unsigned ENT_FREE  = 0;
  localparam int unsigned ENT_END   = 1;
  localparam int unsigned LINK_BASE = 2;

  typedef enum logic [1:0] {
    ACT_WALK  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_CUT   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_SHORT = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_FREE  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_CHK_START,
    ST_WALK,
    ST_SCAN,
    ST_LINK,
    ST_RELEASE,
    ST_DONE
  } state_e;

  typedef struct packed {
    action_e          action;
    logic [BLK_W-1:0] start_block;
    logic             has_tail;
    logic [BLK_W-1:0] steps;
  } item_t;

  typedef struct packed {
    logic [BLK_W-1:0]   block_out;
    status_e            status;
    logic [FREED_W-1:0] freed_count;
  } result_t;

endpackage

FILE: rtl/fce_table_ram.sv
// Link table memory: one write port, one read port, registered read data.
module fce_table_ram #(
  parameter  int unsigned TABLE_BLOCKS = 4096,
  localparam int unsigned ADDR_W       = $clog2(TABLE_BLOCKS),
  localparam int unsigned ENT_W        = $clog2(TABLE_BLOCKS + 2)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [ENT_W-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [ENT_W-1:0]  rdata_o
);

  logic [ENT_W-1:0] mem_q [TABLE_BLOCKS];
  logic [ENT_W-1:0] rdata_q;

  // Read data holds between reads; the sequencer relies on that.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/fce_seq.sv
// Action sequencer: walks, scans and rewrites the link table one entry per cycle.
module fce_seq #(
  parameter  int unsigned TABLE_BLOCKS = 4096,
  localparam int unsigned ADDR_W       = $clog2(TABLE_BLOCKS),
  localparam int unsigned ENT_W        = $clog2(TABLE_BLOCKS + 2)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         item_valid_i,
  output logic                         item_ready_o,
  input  fce_pkg::item_t               item_i,
  input  logic [fce_pkg::CFG_W-1:0]    usable_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output fce_pkg::result_t             res_o,
  output logic                         mem_we_o,
  output logic [ADDR_W-1:0]            mem_waddr_o,
  output logic [ENT_W-1:0]             mem_wdata_o,
  output logic                         mem_re_o,
  output logic [ADDR_W-1:0]            mem_raddr_o,
  input  logic [ENT_W-1:0]             mem_rdata_i
);

  import fce_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_BLOCKS + 1);
  localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [CMP_W-1:0]  TB_C      = CMP_W'(TABLE_BLOCKS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_BLOCKS - 1);
  localparam logic [ENT_W-1:0]  E_FREE    = ENT_W'(ENT_FREE);
  localparam logic [ENT_W-1:0]  E_END     = ENT_W'(ENT_END);
  localparam logic [ENT_W-1:0]  E_BASE    = ENT_W'(LINK_BASE);

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  action_e             act_q, act_d;
  logic [BLK_W-1:0]    start_q, start_d;
  logic                tail_q, tail_d;
  logic [BLK_W-1:0]    steps_q, steps_d;
  logic [ADDR_W-1:0]   cur_q, cur_d;
  logic [ADDR_W-1:0]   nxt_q, nxt_d;     // block whose entry sits in read data
  logic [CNT_W-1:0]    scan_q, scan_d;
  logic [ADDR_W-1:0]   chk_q, chk_d;
  logic                chk_vld_q, chk_vld_d;
  logic                fwd_q, fwd_d;     // read collided with a write
  logic [ENT_W-1:0]    fwd_val_q, fwd_val_d;
  logic [FREED_W-1:0]  cnt_q, cnt_d;
  logic [BLK_W-1:0]    blk_q, blk_d;
  status_e             stat_q, stat_d;

  logic                start_in;
  logic [ADDR_W-1:0]   start_addr;
  logic [CMP_W-1:0]    usable_ext;
  logic [CMP_W-1:0]    lim;
  logic                scan_more;
  logic [ENT_W-1:0]    rd_ent;
  logic [ENT_W-1:0]    rel_ent;
  logic [ADDR_W-1:0]   rd_link;
  logic [ADDR_W-1:0]   rel_link;
  logic [FREED_W-1:0]  cnt_inc;

  assign start_in   = CMP_W'(start_q) < TB_C;
  assign start_addr = ADDR_W'(start_q);
  assign usable_ext = CMP_W'(usable_i);
  assign lim        = (usable_ext > TB_C) ? TB_C : usable_ext;
  assign scan_more  = CMP_W'(scan_q) < lim;
  assign rd_ent     = mem_rdata_i;
  assign rel_ent    = fwd_q ? fwd_val_q : mem_rdata_i;
  assign rd_link    = ADDR_W'(rd_ent - E_BASE);
  assign rel_link   = ADDR_W'(rel_ent - E_BASE);
  assign cnt_inc    = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    act_d       = act_q;
    start_d     = start_q;
    tail_d      = tail_q;
    steps_d     = steps_q;
    cur_d       = cur_q;
    nxt_d       = nxt_q;
    scan_d      = scan_q;
    chk_d       = chk_q;
    chk_vld_d   = chk_vld_q;
    fwd_d       = fwd_q;
    fwd_val_d   = fwd_val_q;
    cnt_d       = cnt_q;
    blk_d       = blk_q;
    stat_d      = stat_q;
    item_ready_o = 1'b0;
    res_valid_o  = 1'b0;
    mem_we_o     = 1'b0;
    mem_waddr_o  = nxt_q;
    mem_wdata_o  = E_FREE;
    mem_re_o     = 1'b0;
    mem_raddr_o  = nxt_q;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = E_FREE;
        clr_d       = clr_q + 1'b1;
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          act_d     = item_i.action;
          start_d   = item_i.start_block;
          tail_d    = item_i.has_tail;
          steps_d   = item_i.steps;
          cnt_d     = '0;
          blk_d     = '0;
          stat_d    = STAT_OK;
          scan_d    = '0;
          chk_vld_d = 1'b0;
          fwd_d     = 1'b0;
          state_d   = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        if (act_q == ACT_ALLOC && !tail_q) begin
          state_d = ST_SCAN;
        end else if (!start_in) begin
          // out-of-range block reads as free
          stat_d  = STAT_FREE;
          state_d = ST_DONE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = start_addr;
          nxt_d       = start_addr;
          cur_d       = start_addr;
          state_d     = ST_CHK_START;
        end
      end

      ST_CHK_START: begin
        if (rd_ent == E_FREE) begin
          stat_d  = STAT_FREE;
          state_d = ST_DONE;
        end else begin
          unique case (act_q)
            ACT_WALK: begin
              if (steps_q == '0) begin
                blk_d   = BLK_W'(cur_q);
                state_d = ST_DONE;
              end else if (rd_ent < E_BASE) begin
                stat_d  = STAT_SHORT;
                blk_d   = BLK_W'(cur_q);
                state_d = ST_DONE;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = rd_link;
                nxt_d       = rd_link;
                state_d     = ST_WALK;
              end
            end
            ACT_ALLOC: begin
              state_d = ST_SCAN;
            end
            ACT_FREE: begin
              // read data still holds the start entry
              state_d = ST_RELEASE;
            end
            ACT_CUT: begin
              mem_we_o    = 1'b1;
              mem_waddr_o = start_addr;
              mem_wdata_o = E_END;
              if (rd_ent >= E_BASE) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = rd_link;
                nxt_d       = rd_link;
                fwd_d       = (rd_link == start_addr);
                fwd_val_d   = E_END;
                state_d     = ST_RELEASE;
              end else begin
                state_d = ST_DONE;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      ST_WALK: begin
        if (rd_ent == E_FREE) begin
          // link into a free block ends the chain at the linking block
          stat_d  = STAT_SHORT;
          blk_d   = BLK_W'(cur_q);
          state_d = ST_DONE;
        end else begin
          cur_d   = nxt_q;
          steps_d = steps_q - 1'b1;
          if (steps_q == BLK_W'(1)) begin
            blk_d   = BLK_W'(nxt_q);
            state_d = ST_DONE;
          end else if (rd_ent < E_BASE) begin
            stat_d  = STAT_SHORT;
            blk_d   = BLK_W'(nxt_q);
            state_d = ST_DONE;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = rd_link;
            nxt_d       = rd_link;
          end
        end
      end

      ST_SCAN: begin
        if (chk_vld_q && rd_ent == E_FREE) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = chk_q;
          mem_wdata_o = E_END;
          blk_d       = BLK_W'(chk_q);
          state_d     = tail_q ? ST_LINK : ST_DONE;
        end else if (scan_more) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ADDR_W'(scan_q);
          chk_d       = ADDR_W'(scan_q);
          chk_vld_d   = 1'b1;
          scan_d      = scan_q + 1'b1;
        end else begin
          stat_d  = STAT_FULL;
          state_d = ST_DONE;
        end
      end

      ST_LINK: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = start_addr;
        mem_wdata_o = ENT_W'(chk_q) + E_BASE;
        state_d     = ST_DONE;
      end

      ST_RELEASE: begin
        if (rel_ent == E_FREE) begin
          state_d = ST_DONE;
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = nxt_q;
          mem_wdata_o = E_FREE;
          cnt_d       = cnt_inc;
          fwd_d       = 1'b0;
          if (rel_ent >= E_BASE) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = rel_link;
            nxt_d       = rel_link;
            fwd_d       = (rel_link == nxt_q);
            fwd_val_d   = E_FREE;
          end else begin
            state_d = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      chk_vld_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      chk_vld_q <= chk_vld_d;
      fwd_q     <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    start_q   <= start_d;
    tail_q    <= tail_d;
    steps_q   <= steps_d;
    cur_q     <= cur_d;
    nxt_q     <= nxt_d;
    scan_q    <= scan_d;
    chk_q     <= chk_d;
    fwd_val_q <= fwd_val_d;
    cnt_q     <= cnt_d;
    blk_q     <= blk_d;
    stat_q    <= stat_d;
  end

  assign res_o.block_out   = blk_q;
  assign res_o.status      = stat_q;
  assign res_o.freed_count = cnt_q;

endmodule

FILE: rtl/fat_chain_engine_top.sv
// Top level of the file allocation table chain engine.
//
// Keeps a table of TABLE_BLOCKS entries (free, end of chain, or link to the
// next block) in one single-port-read, single-port-write memory, and runs one
// action per item: walk, allocate (optionally appended after a tail), free a
// chain, or cut a chain after a block. Items are handled one at a time; every
// item gives exactly one result. Timing is set by the table read port, one
// entry per cycle. A walk runs longer with more steps, shorter when the chain
// ends early; allocate runs longer the higher the lowest free block sits, and
// searches the whole allowed range when full; free and cut run longer with
// more blocks released. Worst case is a full search of the whole table. After
// reset the table is cleared to free, one entry a cycle; s_axis_tready stays
// low meanwhile, while configuration writes are taken at once. usable_blocks
// (cfg_wdata_i) limits the allocate search to the lowest min(usable_blocks,
// TABLE_BLOCKS) entries. The result sits in a one-deep output register, so
// the next item can run while it waits; a second result holds the sequencer
// until the first drains.
module fat_chain_engine_top #(
  parameter int unsigned TABLE_BLOCKS = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fce_pkg::CFG_W-1:0]   cfg_wdata_i,   // usable_blocks
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,  // start_block, has_tail, steps
  input  logic [1:0]                  s_axis_tuser,  // action
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata,  // block_out, freed_count
  output logic [1:0]                  m_axis_tuser   // status
);

  import fce_pkg::*;

  localparam int unsigned ADDR_W = $clog2(TABLE_BLOCKS);
  localparam int unsigned ENT_W  = $clog2(TABLE_BLOCKS + 2);

  logic [CFG_W-1:0]  usable_q, usable_d;
  logic              m_valid_q, m_valid_d;
  result_t           m_res_q, m_res_d;

  item_t             item;
  result_t           res;
  logic              res_valid;
  logic              res_ready;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ENT_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [ENT_W-1:0]  mem_rdata;

  // input item unpack
  assign item.action      = action_e'(s_axis_tuser);
  assign item.start_block = s_axis_tdata[11:0];
  assign item.has_tail    = s_axis_tdata[12];
  assign item.steps       = s_axis_tdata[24:13];

  assign usable_d = cfg_we_i ? cfg_wdata_i : usable_q;

  // output register: loads when empty or being drained
  assign res_ready = !m_valid_q || m_axis_tready;
  always_comb begin
    m_valid_d = m_valid_q;
    m_res_d   = m_res_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      m_valid_d = 1'b1;
      m_res_d   = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usable_q  <= CFG_RESET;
      m_valid_q <= 1'b0;
    end else begin
      usable_q  <= usable_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_res_q <= m_res_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, m_res_q.freed_count, m_res_q.block_out};
  assign m_axis_tuser  = m_res_q.status;

  fce_seq #(
    .TABLE_BLOCKS(TABLE_BLOCKS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_i       (item),
    .usable_i     (usable_q),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  fce_table_ram #(
    .TABLE_BLOCKS(TABLE_BLOCKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

`include "fat_chain_engine_top_macros.svh"

  // idle sequencer leaves the table alone
  `FCE_ASSERT(a_idle_no_mem, clk_i, rst_ni, s_axis_tready |-> (!mem_we && !mem_re))
  // one item at a time
  `FCE_ASSERT(a_one_item, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
  // no pending result while a new item can be taken
  `FCE_ASSERT(a_ready_no_res, clk_i, rst_ni, s_axis_tready |-> !res_valid)
  // nothing moves in the cycle after a reset edge
  `FCE_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> (!m_axis_tvalid && !s_axis_tready))

endmodule

FILE: verif/fat_chain_checker.sv
// Checker for the FAT chain engine: mirrors the link table and compares every result.
module fat_chain_checker #(
  parameter int unsigned TABLE_BLOCKS = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [fce_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic [31:0]               s_axis_tdata,   // start_block, has_tail, steps
  input  logic [1:0]                s_axis_tuser,   // action
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [31:0]               m_axis_tdata,   // block_out, freed_count
  input  logic [1:0]                m_axis_tuser,   // status
  output int unsigned               mismatch_count_o,
  output int unsigned               pending_o,
  output int unsigned               checked_o
);
  import fce_pkg::*;

  localparam int unsigned FREED_MAX   = 8191;
  localparam int unsigned MAX_REPORTS = 10;

  // Entry coding as in the block: free, end of chain, or next block + LINK_BASE.
  logic [13:0]      fat_entry [TABLE_BLOCKS];
  logic [CFG_W-1:0] usable_blocks;
  result_t          expected_results [$];
  int unsigned      mismatches;
  int unsigned      checked;

  // Releases a chain from its head; stops at an end entry or a link to a free block.
  function automatic int unsigned drop_chain(logic [BLK_W-1:0] head);
    logic [BLK_W-1:0] blk;
    logic [13:0]      ent;
    int unsigned      cnt;
    bit               more;
    blk  = head;
    cnt  = 0;
    more = 1'b1;
    while (more && fat_entry[blk] != ENT_FREE) begin
      ent = fat_entry[blk];
      fat_entry[blk] = 14'(ENT_FREE);
      if (cnt < FREED_MAX) cnt++;
      if (ent < LINK_BASE) more = 1'b0;
      else blk = BLK_W'(ent - LINK_BASE);
    end
    return cnt;
  endfunction

  function automatic result_t apply_fat_action(item_t it);
    result_t          r;
    logic [13:0]      ent;
    logic [BLK_W-1:0] cur;
    logic [BLK_W-1:0] nxt;
    int unsigned      lim;
    int unsigned      idx;
    int unsigned      n;
    bit               more;
    r        = '0;
    r.status = STAT_OK;
    case (it.action)
      ACT_WALK: begin
        if (fat_entry[it.start_block] == ENT_FREE) begin
          r.status = STAT_FREE;
        end else begin
          cur  = it.start_block;
          n    = 0;
          more = 1'b1;
          while (more && n < it.steps) begin
            ent = fat_entry[cur];
            if (ent < LINK_BASE) begin
              r.status = STAT_SHORT;
              more     = 1'b0;
            end else begin
              nxt = BLK_W'(ent - LINK_BASE);
              // a link into a free block ends the walk where the link sits
              if (fat_entry[nxt] == ENT_FREE) begin
                r.status = STAT_SHORT;
                more     = 1'b0;
              end else begin
                cur = nxt;
              end
            end
            n++;
          end
          r.block_out = cur;
        end
      end
      ACT_ALLOC: begin
        if (it.has_tail && fat_entry[it.start_block] == ENT_FREE) begin
          r.status = STAT_FREE;
        end else begin
          lim = (usable_blocks > TABLE_BLOCKS) ? TABLE_BLOCKS : usable_blocks;
          idx = 0;
          while (idx < lim && fat_entry[BLK_W'(idx)] != ENT_FREE) idx++;
          if (idx >= lim) begin
            r.status = STAT_FULL;
          end else begin
            fat_entry[BLK_W'(idx)] = 14'(ENT_END);
            if (it.has_tail) fat_entry[it.start_block] = 14'(idx + LINK_BASE);
            r.block_out = BLK_W'(idx);
          end
        end
      end
      ACT_FREE: begin
        if (fat_entry[it.start_block] == ENT_FREE) r.status = STAT_FREE;
        else r.freed_count = FREED_W'(drop_chain(it.start_block));
      end
      default: begin
        ent = fat_entry[it.start_block];
        if (ent == ENT_FREE) begin
          r.status = STAT_FREE;
        end else begin
          fat_entry[it.start_block] = 14'(ENT_END);
          if (ent >= LINK_BASE)
            r.freed_count = FREED_W'(drop_chain(BLK_W'(ent - LINK_BASE)));
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_p
    item_t   it;
    result_t want;
    result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_BLOCKS; i++) fat_entry[i] = 14'(ENT_FREE);
      usable_blocks = CFG_RESET;
      expected_results.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      // results first: a result never belongs to an item taken at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got.block_out   = m_axis_tdata[11:0];
        got.freed_count = m_axis_tdata[24:12];
        got.status      = status_e'(m_axis_tuser);
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result: block %0d status %0d freed %0d", $realtime,
                     got.block_out, got.status, got.freed_count);
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (got.block_out !== want.block_out || got.status !== want.status ||
              got.freed_count !== want.freed_count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"%0t: result %0d mismatch: exp block %0d status %0d freed %0d,",
                        " got block %0d status %0d freed %0d"},
                       $realtime, checked, want.block_out, want.status, want.freed_count,
                       got.block_out, got.status, got.freed_count);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        it.action      = action_e'(s_axis_tuser);
        it.start_block = s_axis_tdata[11:0];
        it.has_tail    = s_axis_tdata[12];
        it.steps       = s_axis_tdata[24:13];
        expected_results.push_back(apply_fat_action(it));
      end
      if (cfg_we_i) usable_blocks = cfg_wdata_i;
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_results.size();
    checked_o        <= checked;
  end

endmodule

FILE: verif/tb_fat_chain_engine_top.sv
// Testbench top for the FAT chain engine: clock, reset, stimulus, stalls and verdict.
module tb_fat_chain_engine_top;
  import fce_pkg::*;

  localparam int unsigned TABLE_BLOCKS    = 4096;
  // Watchdog limit, above the slowest item, the clearing pass and the long stall.
  localparam int unsigned IDLE_LIMIT      = 20000;
  localparam int unsigned LONG_HOLD       = 300;
  localparam int unsigned ITEMS_PER_PHASE = 23;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned MAX_GAP         = 19;

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             cfg_we        = 1'b0;
  logic [CFG_W-1:0] cfg_wdata     = '0;
  logic             s_axis_tvalid = 1'b0;
  logic [31:0]      s_axis_tdata  = '0;
  logic [1:0]       s_axis_tuser  = '0;
  logic             m_axis_tready = 1'b0;
  logic             s_axis_tready;
  logic             m_axis_tvalid;
  logic [31:0]      m_axis_tdata;
  logic [1:0]       m_axis_tuser;

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned checked;

  // Idle shaping, set per phase by the stimulus process.
  bit          tx_no_gap    = 1'b0;
  bit          rx_no_gap    = 1'b0;
  int unsigned rx_long_hold = 0;

  int unsigned sent_by_action [4] = '{0, 0, 0, 0};
  int unsigned settings_used      = 0;
  int unsigned idle_cycles        = 0;

  initial forever #5 clk = ~clk;

  fat_chain_engine_top #(
    .TABLE_BLOCKS (TABLE_BLOCKS)
  ) u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  fat_chain_checker #(
    .TABLE_BLOCKS (TABLE_BLOCKS)
  ) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  // Offers one item after a random gap. With no gap, tvalid stays high and
  // only the payload changes, so tvalid never sees two updates in one step.
  task automatic send_item(action_e act, logic [BLK_W-1:0] start, logic tail,
                           logic [BLK_W-1:0] steps);
    int unsigned gap;
    gap = tx_no_gap ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, steps, tail, start};
    s_axis_tuser  <= act;
    do @(posedge clk); while (!s_axis_tready);
    sent_by_action[int'(act)]++;
  endtask

  // Random item. Most start blocks fall in the small range that allocate
  // hands out, so walks, frees and cuts mostly hit live chains; the rest are
  // spread over the whole table as noise.
  task automatic send_random(int unsigned usable);
    int unsigned      span;
    int unsigned      roll;
    action_e          act;
    logic [BLK_W-1:0] start;
    logic [BLK_W-1:0] steps;
    logic             tail;
    span  = (usable < 62) ? usable + 2 : 64;
    roll  = $urandom_range(0, 99);
    act   = (roll < 40) ? ACT_ALLOC : (roll < 65) ? ACT_WALK : (roll < 80) ? ACT_FREE : ACT_CUT;
    start = ($urandom_range(0, 99) < 85) ? BLK_W'($urandom_range(0, span - 1))
                                         : BLK_W'($urandom);
    tail  = ($urandom_range(0, 99) < 70);
    steps = ($urandom_range(0, 99) < 80) ? BLK_W'($urandom_range(0, 12)) : BLK_W'($urandom);
    send_item(act, start, tail, steps);
  endtask

  // Stops offering, waits until every result is back, then a short settle.
  // The first edge lets the checker count the last accepted item.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_usable(logic [CFG_W-1:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  // Receiver: per result a random hold-off with tready low, or one long
  // hold-off when the stimulus asks for backpressure.
  initial begin : receiver
    int unsigned hold;
    bit          long_taken;
    long_taken = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (rx_long_hold > 0 && !long_taken) begin
        hold       = rx_long_hold;
        long_taken = 1'b1;
      end else begin
        hold = rx_no_gap ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // Watchdog: too long with no item moving on either side ends the run.
  always @(posedge clk) begin
    if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
               idle_cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned usable_plan [5];
    usable_plan = '{16, 1, 4096, 64, 5};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Written during the clearing pass; the block takes it at once.
    set_usable(13'd4096);

    // Directed: empty table, chain building, overwrite of a non-end tail,
    // short walks, links into freed blocks, and ends being cut.
    send_item(ACT_WALK,  12'd0,    1'b0, 12'd0);     // walk from a free block
    send_item(ACT_FREE,  12'd5,    1'b0, 12'd0);     // free at a free block
    send_item(ACT_CUT,   12'd7,    1'b0, 12'd0);     // cut at a free block
    send_item(ACT_ALLOC, 12'd0,    1'b0, 12'd0);     // new chain -> 0
    send_item(ACT_ALLOC, 12'd0,    1'b1, 12'd0);     // 0 -> 1
    send_item(ACT_ALLOC, 12'd1,    1'b1, 12'd0);     // 1 -> 2
    send_item(ACT_ALLOC, 12'd0,    1'b1, 12'd0);     // 0 relinked to 3, 1 -> 2 left alone
    send_item(ACT_WALK,  12'd0,    1'b0, 12'd0);     // zero steps
    send_item(ACT_WALK,  12'd0,    1'b0, 12'd4095);  // hits end early
    send_item(ACT_WALK,  12'd1,    1'b0, 12'd1);
    send_item(ACT_ALLOC, 12'd4095, 1'b1, 12'd0);     // append after a free tail
    send_item(ACT_WALK,  12'd4095, 1'b1, 12'd4095);  // top block, all bits set
    send_item(ACT_CUT,   12'd3,    1'b0, 12'd0);     // cut at an end block
    send_item(ACT_CUT,   12'd1,    1'b0, 12'd0);
    send_item(ACT_FREE,  12'd0,    1'b0, 12'd0);
    send_item(ACT_ALLOC, 12'd0,    1'b0, 12'd0);
    send_item(ACT_ALLOC, 12'd0,    1'b1, 12'd0);
    send_item(ACT_FREE,  12'd2,    1'b0, 12'd0);     // leaves a link into a free block
    send_item(ACT_WALK,  12'd0,    1'b0, 12'd3);     // walk stops at that link
    send_item(ACT_CUT,   12'd0,    1'b0, 12'd0);     // remainder already free
    send_item(ACT_FREE,  12'd0,    1'b0, 12'd0);
    drain();

    // Table full within a tiny search range.
    set_usable(13'd2);
    send_item(ACT_ALLOC, 12'd0,    1'b0, 12'd0);
    send_item(ACT_ALLOC, 12'd0,    1'b0, 12'd0);
    send_item(ACT_FREE,  12'd0,    1'b0, 12'd0);
    send_item(ACT_FREE,  12'd1,    1'b0, 12'd0);
    drain();

    // Random phases over several search ranges; phase 2 runs the sender flat
    // out against a long output stall, phase 3 has no idling at all.
    for (int ph = 0; ph < 5; ph++) begin
      set_usable(CFG_W'(usable_plan[ph]));
      tx_no_gap = (ph == 2) || (ph == 3);
      rx_no_gap = (ph == 3);
      if (ph == 2) rx_long_hold = LONG_HOLD;
      repeat (ITEMS_PER_PHASE) send_random(usable_plan[ph]);
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Run covered %0d walks, %0d allocates, %0d frees and %0d cuts",
             sent_by_action[0], sent_by_action[1], sent_by_action[2], sent_by_action[3]);
    $display("%0d results checked over %0d search-range settings, with one long output stall",
             checked, settings_used);
    if (mismatch_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
